// ===== hdl/light_sensor_lux_calc_assert.svh =====
// ---------------------------------------------------------------------------
// Light sensor lux calculator: assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_LUX_CALC_ASSERT_SVH
`define LIGHT_SENSOR_LUX_CALC_ASSERT_SVH
`ifndef SYNTHESIS
`define LSL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LSL_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
      else $error("assertion failed after reset");
`else
`define LSL_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSL_ASSERT_AFTER_RESET(label, clk, rst, cons)
`endif
`endif

// ===== hdl/lsl_pkg.sv =====
// ---------------------------------------------------------------------------
// lsl_pkg
// Types, constants and table helper for the light sensor lux calculator.
// ---------------------------------------------------------------------------
package lsl_pkg;

   localparam int RATIO_FRAC_BITS     = 12;
   localparam int POWER_TABLE_ENTRIES = 64;

   localparam int COUNT_W  = 16;
   localparam int LUX_W    = 24;
   localparam int STATUS_W = 2;
   localparam int P_W      = 16;
   localparam int COEF_W   = 28;
   localparam int DIFF_W   = 29;
   localparam int MAG_W    = 44;
   localparam int NUM_W    = 12;
   localparam int DEN_W    = 36;
   localparam int ACC_W    = 60;

   localparam logic [COUNT_W-1:0] COUNT_SAT = 16'hFFFF;
   localparam logic [LUX_W-1:0]   LUX_MAX   = 24'hFFFFFF;

   // register indexes
   localparam logic CSR_HIGH_GAIN   = 1'b0;
   localparam logic CSR_INTEGRATION = 1'b1;

   // integration codes
   localparam logic [1:0] INT_13MS  = 2'd0;
   localparam logic [1:0] INT_101MS = 2'd1;
   localparam logic [1:0] INT_402MS = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RATIO = 2'd3;

   // linear piece codes
   localparam logic [1:0] PIECE_POWER = 2'd0;
   localparam logic [1:0] PIECE_MID   = 2'd1;
   localparam logic [1:0] PIECE_HIGH  = 2'd2;
   localparam logic [1:0] PIECE_TOP   = 2'd3;

   // integration factors, denominators in units of 1e-5 * 2^8
   localparam logic [NUM_W-1:0] NUM_13MS  = 12'd4020;
   localparam logic [NUM_W-1:0] NUM_101MS = 12'd402;
   localparam logic [NUM_W-1:0] NUM_402MS = 12'd1;
   localparam logic [DEN_W-1:0] DEN_13MS  = 36'd3507200000;
   localparam logic [DEN_W-1:0] DEN_101MS = 36'd2585600000;
   localparam logic [DEN_W-1:0] DEN_402MS = 36'd25600000;

   localparam logic [COEF_W-1:0] POWER_BASE = 28'd199229440;

   typedef struct packed {
      logic [COUNT_W-1:0] full_count;
      logic [COUNT_W-1:0] infrared_count;
   } lsl_req_type;

   typedef struct packed {
      logic [LUX_W-1:0]    lux_value;
      logic [STATUS_W-1:0] lux_status;
   } lsl_rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  full_count;
      logic [COUNT_W-1:0]  infrared_count;
      logic [STATUS_W-1:0] status;
      logic [1:0]          piece;
   } lsl_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                ovf;
   } lsl_tail_type;

   // largest y in 0..4096 with y^5 <= target
   function automatic logic [12:0] root5(input logic [63:0] target);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p5;
      lo = 64'd0;
      hi = 64'd4096;
      mid = 64'd0;
      p5 = 64'd0;
      for (int s = 0; s < 14; s++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p5 = mid * mid * mid * mid * mid;
            if (p5 <= target) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      return lo[12:0];
   endfunction

endpackage

// ===== hdl/lsl_ratio_cell.sv =====
// ---------------------------------------------------------------------------
// lsl_ratio_cell
// One restoring step of the infrared/full ratio divider.
// ---------------------------------------------------------------------------
module lsl_ratio_cell #(
   parameter int RATIO_FRAC_BITS = lsl_pkg::RATIO_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  lsl_pkg::lsl_item_type        in_item,
   input  logic [15:0]                  in_rem,
   input  logic [RATIO_FRAC_BITS-1:0]   in_q,
   output logic                         out_valid,
   input  logic                         out_ready,
   output lsl_pkg::lsl_item_type        out_item,
   output logic [15:0]                  out_rem,
   output logic [RATIO_FRAC_BITS-1:0]   out_q
);

   logic                       valid_ff;
   lsl_pkg::lsl_item_type      item_ff;
   logic [15:0]                rem_ff;
   logic [15:0]                rem_in;
   logic [RATIO_FRAC_BITS-1:0] q_ff;
   logic [RATIO_FRAC_BITS-1:0] q_in;
   logic [16:0]                rem2;
   logic [16:0]                diff;
   logic                       ge;

   assign rem2 = {in_rem, 1'b0};
   assign diff = rem2 - {1'b0, in_item.full_count};
   assign ge   = rem2 >= {1'b0, in_item.full_count};

   always_comb begin
      rem_in = ge ? diff[15:0] : rem2[15:0];
      q_in   = {in_q[RATIO_FRAC_BITS-2:0], ge};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;

endmodule

// ===== hdl/lsl_lux_cell.sv =====
// ---------------------------------------------------------------------------
// lsl_lux_cell
// One restoring step of the division by the scale denominator.
// ---------------------------------------------------------------------------
module lsl_lux_cell #(
   parameter int SHIFT = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lsl_pkg::DEN_W-1:0]        den,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  lsl_pkg::lsl_tail_type            in_tail,
   input  logic [lsl_pkg::ACC_W-1:0]        in_rem,
   input  logic [lsl_pkg::LUX_W-1:0]        in_q,
   output logic                             out_valid,
   input  logic                             out_ready,
   output lsl_pkg::lsl_tail_type            out_tail,
   output logic [lsl_pkg::ACC_W-1:0]        out_rem,
   output logic [lsl_pkg::LUX_W-1:0]        out_q
);

   logic                          valid_ff;
   lsl_pkg::lsl_tail_type         tail_ff;
   logic [lsl_pkg::ACC_W-1:0]     rem_ff;
   logic [lsl_pkg::ACC_W-1:0]     rem_in;
   logic [lsl_pkg::LUX_W-1:0]     q_ff;
   logic [lsl_pkg::LUX_W-1:0]     q_in;
   logic [lsl_pkg::ACC_W-1:0]     shifted;
   logic                          ge;

   assign shifted = lsl_pkg::ACC_W'(den) << SHIFT;
   assign ge      = in_rem >= shifted;

   always_comb begin
      rem_in = ge ? (in_rem - shifted) : in_rem;
      q_in   = in_q | (ge ? (lsl_pkg::LUX_W'(1) << SHIFT) : '0);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         tail_ff <= in_tail;
         rem_ff  <= rem_in;
         q_ff    <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tail  = tail_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;

endmodule

// ===== hdl/lsl_calc.sv =====
// ---------------------------------------------------------------------------
// lsl_calc
// Power table lookup, piece sums, scaling and overflow check (7 stages).
// ---------------------------------------------------------------------------
module lsl_calc #(
   parameter int RATIO_FRAC_BITS     = lsl_pkg::RATIO_FRAC_BITS,
   parameter int POWER_TABLE_ENTRIES = lsl_pkg::POWER_TABLE_ENTRIES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lsl_pkg::NUM_W-1:0]    num,
   input  logic [lsl_pkg::DEN_W-1:0]    den,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  lsl_pkg::lsl_item_type        in_item,
   input  logic [RATIO_FRAC_BITS-1:0]   in_q,
   output logic                         out_valid,
   input  logic                         out_ready,
   output lsl_pkg::lsl_tail_type        out_tail,
   output logic [lsl_pkg::ACC_W-1:0]    out_rem
);

   localparam int          F     = RATIO_FRAC_BITS;
   localparam int          N     = POWER_TABLE_ENTRIES;
   localparam int          K_W   = $clog2(N + 1);
   localparam int          POS_W = F + $clog2(2 * N + 1);
   localparam logic [63:0] N64   = 64'(N);
   localparam logic [63:0] NSQ   = N64 * N64;
   localparam int          STAGES = 7;

   // x^1.4 table, Q16, points 0..N over ratio 0..0.5
   logic [lsl_pkg::P_W-1:0] tab [N+1];

   for (genvar i = 0; i <= N; i++) begin : g_tab
      localparam logic [63:0] T  = ((64'(i) * 64'(i)) << 42) / NSQ;
      localparam logic [63:0] YR = 64'(lsl_pkg::root5(T << 16));
      localparam logic [63:0] PV = (64'(i) * YR * 64'd8) / N64;
      assign tab[i] = PV[lsl_pkg::P_W-1:0];
   end

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   rdy;

   assign rdy[STAGES] = out_ready;
   for (genvar s = 0; s < STAGES; s++) begin : g_rdy
      assign rdy[s] = !v_ff[s] || rdy[s+1];
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int s = 1; s < STAGES; s++) begin
            if (rdy[s]) begin
               v_ff[s] <= v_ff[s-1];
            end
         end
      end
   end

   // stage 1: table position
   lsl_pkg::lsl_item_type item1_ff;
   logic [K_W-1:0]        k1_ff;
   logic [F-1:0]          f1_ff;
   logic [POS_W-1:0]      pos;

   assign pos = POS_W'(in_q) * POS_W'(2 * N);

   always_ff @(posedge clock) begin
      if (in_valid && rdy[0]) begin
         item1_ff <= in_item;
         k1_ff    <= pos[F+K_W-1:F];
         f1_ff    <= pos[F-1:0];
      end
   end

   // stage 2: neighbouring table points
   lsl_pkg::lsl_item_type   item2_ff;
   logic [lsl_pkg::P_W-1:0] a2_ff;
   logic [lsl_pkg::P_W-1:0] d2_ff;
   logic [F-1:0]            f2_ff;
   logic [lsl_pkg::P_W-1:0] a_in;
   logic [lsl_pkg::P_W-1:0] d_in;

   always_comb begin
      if (k1_ff >= K_W'(N)) begin
         a_in = tab[N];
         d_in = '0;
      end else begin
         a_in = tab[k1_ff];
         d_in = tab[k1_ff + K_W'(1)] - tab[k1_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (v_ff[0] && rdy[1]) begin
         item2_ff <= item1_ff;
         a2_ff    <= a_in;
         d2_ff    <= d_in;
         f2_ff    <= f1_ff;
      end
   end

   // stage 3: interpolation
   lsl_pkg::lsl_item_type      item3_ff;
   logic [lsl_pkg::P_W-1:0]    p3_ff;
   logic [lsl_pkg::P_W+F-1:0]  prod;

   assign prod = (lsl_pkg::P_W+F)'(d2_ff) * (lsl_pkg::P_W+F)'(f2_ff);

   always_ff @(posedge clock) begin
      if (v_ff[1] && rdy[2]) begin
         item3_ff <= item2_ff;
         p3_ff    <= a2_ff + prod[lsl_pkg::P_W+F-1:F];
      end
   end

   // stage 4: coefficient of the power piece, difference of the others
   lsl_pkg::lsl_item_type              item4_ff;
   logic [lsl_pkg::COEF_W-1:0]         c4_ff;
   logic signed [lsl_pkg::DIFF_W-1:0]  diff4_ff;
   logic signed [lsl_pkg::DIFF_W-1:0]  diff_in;
   logic [lsl_pkg::DIFF_W-1:0]         fc;
   logic [lsl_pkg::DIFF_W-1:0]         ic;

   assign fc = lsl_pkg::DIFF_W'(item3_ff.full_count);
   assign ic = lsl_pkg::DIFF_W'(item3_ff.infrared_count);

   always_comb begin
      case (item3_ff.piece)
         lsl_pkg::PIECE_MID:
            diff_in = $signed(fc * 29'd2240) - $signed(ic * 29'd3100);
         lsl_pkg::PIECE_HIGH:
            diff_in = $signed(fc * 29'd1280) - $signed(ic * 29'd1530);
         lsl_pkg::PIECE_TOP:
            diff_in = $signed(fc * 29'd146) - $signed(ic * 29'd112);
         default:
            diff_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (v_ff[2] && rdy[3]) begin
         item4_ff <= item3_ff;
         c4_ff    <= lsl_pkg::POWER_BASE - lsl_pkg::COEF_W'(p3_ff) * 28'd6200;
         diff4_ff <= diff_in;
      end
   end

   // stage 5: clamped magnitude
   lsl_pkg::lsl_item_type      item5_ff;
   logic [lsl_pkg::MAG_W-1:0]  mag5_ff;
   logic [lsl_pkg::MAG_W-1:0]  mag_in;

   always_comb begin
      if (item4_ff.piece == lsl_pkg::PIECE_POWER) begin
         mag_in = lsl_pkg::MAG_W'(c4_ff) * lsl_pkg::MAG_W'(item4_ff.full_count);
      end else if (diff4_ff < 0) begin
         mag_in = '0;
      end else begin
         mag_in = {diff4_ff[lsl_pkg::COEF_W-1:0], 16'h0000};
      end
   end

   always_ff @(posedge clock) begin
      if (v_ff[3] && rdy[4]) begin
         item5_ff <= item4_ff;
         mag5_ff  <= mag_in;
      end
   end

   // stage 6: integration factor and rounding bias
   lsl_pkg::lsl_item_type      item6_ff;
   logic [lsl_pkg::ACC_W-1:0]  y6_ff;

   always_ff @(posedge clock) begin
      if (v_ff[4] && rdy[5]) begin
         item6_ff <= item5_ff;
         y6_ff    <= lsl_pkg::ACC_W'(mag5_ff) * lsl_pkg::ACC_W'(num)
                   + lsl_pkg::ACC_W'(den >> 1);
      end
   end

   // stage 7: saturation check
   lsl_pkg::lsl_tail_type      tail7_ff;
   logic [lsl_pkg::ACC_W-1:0]  rem7_ff;
   logic                       ovf;

   assign ovf = y6_ff >= (lsl_pkg::ACC_W'(den) << lsl_pkg::LUX_W);

   always_ff @(posedge clock) begin
      if (v_ff[5] && rdy[6]) begin
         tail7_ff.status <= item6_ff.status;
         tail7_ff.ovf    <= ovf;
         rem7_ff         <= ovf ? '0 : y6_ff;
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_tail  = tail7_ff;
   assign out_rem   = rem7_ff;

endmodule

// ===== hdl/light_sensor_lux_calc.sv =====
// ---------------------------------------------------------------------------
// light_sensor_lux_calc
// Two-channel light sensor counts to illuminance in unsigned Q16.8.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel: one transaction carries a full-spectrum and an infrared
//    count. rsp_ channel: one transaction back per request, lux_value and
//    lux_status, in request order.
//  - csr_ port: index 0 high_gain, index 1 integration_select; write only
//    while no transaction is in flight.
//  - Throughput: one transaction per cycle while rsp_ready is high, set
//    by the ratio and division cell rows, each cell a register stage.
//  - Register path from request to response: entry stage, one ratio
//    cell per fraction bit, seven calculation stages, 24 division cells
//    and the output register.
//  - Reset empties every stage and loads high_gain 0 and 402 ms.
//  - A stalled receiver holds the response; each stage keeps taking data
//    while any stage downstream is empty, so req_ready drops only when
//    every stage is full.
// ---------------------------------------------------------------------------
`include "light_sensor_lux_calc_assert.svh"

module light_sensor_lux_calc #(
   parameter int RATIO_FRAC_BITS     = lsl_pkg::RATIO_FRAC_BITS,
   parameter int POWER_TABLE_ENTRIES = lsl_pkg::POWER_TABLE_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lsl_pkg::lsl_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lsl_pkg::lsl_rsp_type rsp_payload,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [1:0]           csr_write_data
);

   localparam int F    = RATIO_FRAC_BITS;
   localparam int QDIV = lsl_pkg::LUX_W;

   // configuration registers
   logic       high_gain_ff;
   logic [1:0] integration_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         high_gain_ff   <= 1'b0;
         integration_ff <= lsl_pkg::INT_402MS;
      end else if (csr_write_enable) begin
         case (csr_index)
            lsl_pkg::CSR_HIGH_GAIN:   high_gain_ff   <= csr_write_data[0];
            lsl_pkg::CSR_INTEGRATION: integration_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // integration factor num/den; the unused code behaves as 402 ms
   logic [lsl_pkg::NUM_W-1:0] num;
   logic [lsl_pkg::DEN_W-1:0] den_base;
   logic [lsl_pkg::DEN_W-1:0] den;

   always_comb begin
      case (integration_ff)
         lsl_pkg::INT_13MS: begin
            num      = lsl_pkg::NUM_13MS;
            den_base = lsl_pkg::DEN_13MS;
         end
         lsl_pkg::INT_101MS: begin
            num      = lsl_pkg::NUM_101MS;
            den_base = lsl_pkg::DEN_101MS;
         end
         default: begin
            num      = lsl_pkg::NUM_402MS;
            den_base = lsl_pkg::DEN_402MS;
         end
      endcase
      // 16x gain: divide by 16 more
      den = high_gain_ff ? (den_base << 4) : den_base;
   end

   // entry stage: status and piece selection
   logic [23:0]           ir100;
   logic [23:0]           full50;
   logic [23:0]           full61;
   logic [23:0]           full80;
   logic [23:0]           full130;
   lsl_pkg::lsl_item_type entry_in;
   lsl_pkg::lsl_item_type entry_ff;
   logic [15:0]           entry_rem_ff;
   logic                  entry_v_ff;
   logic                  entry_ready;

   assign ir100   = 24'(req_payload.infrared_count) * 24'd100;
   assign full50  = 24'(req_payload.full_count) * 24'd50;
   assign full61  = 24'(req_payload.full_count) * 24'd61;
   assign full80  = 24'(req_payload.full_count) * 24'd80;
   assign full130 = 24'(req_payload.full_count) * 24'd130;

   always_comb begin
      entry_in.full_count     = req_payload.full_count;
      entry_in.infrared_count = req_payload.infrared_count;
      // zero count first, then saturated channel, then ratio above 1.30
      if (req_payload.full_count == '0) begin
         entry_in.status = lsl_pkg::ST_ZERO;
      end else if (req_payload.full_count == lsl_pkg::COUNT_SAT ||
                   req_payload.infrared_count == lsl_pkg::COUNT_SAT) begin
         entry_in.status = lsl_pkg::ST_SAT;
      end else if (ir100 > full130) begin
         entry_in.status = lsl_pkg::ST_RATIO;
      end else begin
         entry_in.status = lsl_pkg::ST_VALID;
      end
      if (ir100 <= full50) begin
         entry_in.piece = lsl_pkg::PIECE_POWER;
      end else if (ir100 <= full61) begin
         entry_in.piece = lsl_pkg::PIECE_MID;
      end else if (ir100 <= full80) begin
         entry_in.piece = lsl_pkg::PIECE_HIGH;
      end else begin
         entry_in.piece = lsl_pkg::PIECE_TOP;
      end
   end

   assign req_ready = entry_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_v_ff <= 1'b0;
      end else if (entry_ready) begin
         entry_v_ff <= req_valid;
      end
   end

   // divider starts from ir only in the power piece, where ir < full
   always_ff @(posedge clock) begin
      if (req_valid && entry_ready) begin
         entry_ff     <= entry_in;
         entry_rem_ff <= (entry_in.status == lsl_pkg::ST_VALID &&
                          entry_in.piece == lsl_pkg::PIECE_POWER) ?
                         req_payload.infrared_count : '0;
      end
   end

   // row of ratio cells, one quotient bit each
   logic                  rc_valid [F+1];
   logic                  rc_ready [F+1];
   lsl_pkg::lsl_item_type rc_item  [F+1];
   logic [15:0]           rc_rem   [F+1];
   logic [F-1:0]          rc_q     [F+1];

   assign rc_valid[0] = entry_v_ff;
   assign rc_item[0]  = entry_ff;
   assign rc_rem[0]   = entry_rem_ff;
   assign rc_q[0]     = '0;
   assign entry_ready = !entry_v_ff || rc_ready[0];

   for (genvar i = 0; i < F; i++) begin : g_ratio
      lsl_ratio_cell #(
         .RATIO_FRAC_BITS (F)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (rc_valid[i]),
         .in_ready  (rc_ready[i]),
         .in_item   (rc_item[i]),
         .in_rem    (rc_rem[i]),
         .in_q      (rc_q[i]),
         .out_valid (rc_valid[i+1]),
         .out_ready (rc_ready[i+1]),
         .out_item  (rc_item[i+1]),
         .out_rem   (rc_rem[i+1]),
         .out_q     (rc_q[i+1])
      );
   end

   // table, piece sums and scaling
   logic                  lc_valid [QDIV+1];
   logic                  lc_ready [QDIV+1];
   lsl_pkg::lsl_tail_type lc_tail  [QDIV+1];
   logic [lsl_pkg::ACC_W-1:0] lc_rem [QDIV+1];
   logic [lsl_pkg::LUX_W-1:0] lc_q   [QDIV+1];

   lsl_calc #(
      .RATIO_FRAC_BITS     (F),
      .POWER_TABLE_ENTRIES (POWER_TABLE_ENTRIES)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .num       (num),
      .den       (den),
      .in_valid  (rc_valid[F]),
      .in_ready  (rc_ready[F]),
      .in_item   (rc_item[F]),
      .in_q      (rc_q[F]),
      .out_valid (lc_valid[0]),
      .out_ready (lc_ready[0]),
      .out_tail  (lc_tail[0]),
      .out_rem   (lc_rem[0])
   );

   assign lc_q[0] = '0;

   // row of division cells, quotient bit 23 down to 0
   for (genvar j = 0; j < QDIV; j++) begin : g_lux
      lsl_lux_cell #(
         .SHIFT (QDIV - 1 - j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .den       (den),
         .in_valid  (lc_valid[j]),
         .in_ready  (lc_ready[j]),
         .in_tail   (lc_tail[j]),
         .in_rem    (lc_rem[j]),
         .in_q      (lc_q[j]),
         .out_valid (lc_valid[j+1]),
         .out_ready (lc_ready[j+1]),
         .out_tail  (lc_tail[j+1]),
         .out_rem   (lc_rem[j+1]),
         .out_q     (lc_q[j+1])
      );
   end

   // output register
   logic                 out_v_ff;
   lsl_pkg::lsl_rsp_type out_ff;
   lsl_pkg::lsl_rsp_type out_in;

   always_comb begin
      out_in.lux_status = lc_tail[QDIV].status;
      if (lc_tail[QDIV].status != lsl_pkg::ST_VALID) begin
         out_in.lux_value = '0;
      end else if (lc_tail[QDIV].ovf) begin
         out_in.lux_value = lsl_pkg::LUX_MAX;
      end else begin
         out_in.lux_value = lc_q[QDIV];
      end
   end

   assign lc_ready[QDIV] = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (lc_ready[QDIV]) begin
         out_v_ff <= lc_valid[QDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (lc_valid[QDIV] && lc_ready[QDIV]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   // checks
   // request side blocks only when the whole pipe is full and stalled
   `LSL_ASSERT_SAME(a_ready_only_when_full, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   // a rejected reading never reports illuminance
   `LSL_ASSERT_SAME(a_status_zero_lux, clock, reset,
      rsp_valid && rsp_payload.lux_status != lsl_pkg::ST_VALID, rsp_payload.lux_value == '0)
   // nothing comes out straight after reset
   `LSL_ASSERT_AFTER_RESET(a_empty_after_reset, clock, reset, !rsp_valid)

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Transaction-level test of light_sensor_lux_calc: directed and random count
// pairs under all gain and integration settings, checked against a predictor.
// ---------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = lsl_pkg::RATIO_FRAC_BITS + 33;
   localparam int FRAC    = lsl_pkg::RATIO_FRAC_BITS;
   localparam int ENTRIES = lsl_pkg::POWER_TABLE_ENTRIES;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   lsl_pkg::lsl_req_type req_payload;
   logic                 rsp_valid;
   logic                 rsp_ready;
   lsl_pkg::lsl_rsp_type rsp_payload;
   logic                 csr_write_enable;
   logic                 csr_index;
   logic [1:0]           csr_write_data;

   // predictor copy of the registers
   logic       gain_hi;
   logic [1:0] int_sel;

   lsl_pkg::lsl_rsp_type lux_expected[$];
   int          fail_count;
   int          rsp_count;
   int          req_count;
   bit          no_idle;       // stretch with no idling on either side
   longint      pow_tab[0:ENTRIES];

   light_sensor_lux_calc dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ratio^1.4 table, built from scratch: x^0.4 by search on the fifth power
   function automatic longint fifth_root_q12(longint unsigned goal);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 4096;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid * mid * mid * mid <= goal) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   initial begin
      longint unsigned n, t;
      n = ENTRIES;
      for (int i = 0; i <= ENTRIES; i++) begin
         t = ((longint'(i) * i) << 42) / (n * n);
         pow_tab[i] = (i * fifth_root_q12(t << 16) * 8) / n;
      end
   end

   function automatic lsl_pkg::lsl_rsp_type lux_of(lsl_pkg::lsl_req_type r);
      longint unsigned fc, ic, ratio, pos, k, f, p, mag, num, den, lux;
      longint sum;
      lsl_pkg::lsl_rsp_type o;
      fc = r.full_count;
      ic = r.infrared_count;
      o.lux_value = '0;
      if (fc == 0) begin
         o.lux_status = lsl_pkg::ST_ZERO;
         return o;
      end
      if (fc == 16'hFFFF || ic == 16'hFFFF) begin
         o.lux_status = lsl_pkg::ST_SAT;
         return o;
      end
      if (100 * ic > 130 * fc) begin
         o.lux_status = lsl_pkg::ST_RATIO;
         return o;
      end
      if (100 * ic <= 50 * fc) begin
         ratio = (ic << FRAC) / fc;
         pos = ratio * 2 * ENTRIES;
         k = pos >> FRAC;
         f = pos & ((64'd1 << FRAC) - 1);
         if (k >= ENTRIES) p = pow_tab[ENTRIES];
         else p = pow_tab[k] + (((pow_tab[k+1] - pow_tab[k]) * f) >> FRAC);
         sum = longint'((3040 * fc) << 16) - longint'(6200 * fc * p);
      end else if (100 * ic <= 61 * fc) begin
         sum = (longint'(2240 * fc) - longint'(3100 * ic)) * 65536;
      end else if (100 * ic <= 80 * fc) begin
         sum = (longint'(1280 * fc) - longint'(1530 * ic)) * 65536;
      end else begin
         sum = (longint'(146 * fc) - longint'(112 * ic)) * 65536;
      end
      mag = (sum < 0) ? 0 : sum;
      num = 1;
      den = 1;
      if (int_sel == lsl_pkg::INT_13MS) begin
         num = 4020;
         den = 137;
      end else if (int_sel == lsl_pkg::INT_101MS) begin
         num = 402;
         den = 101;
      end
      den = den * 256 * 100000 * (gain_hi ? 16 : 1);
      lux = (mag * num + den / 2) / den;
      if (lux > 64'hFFFFFF) lux = 64'hFFFFFF;
      o.lux_value = lux[23:0];
      o.lux_status = lsl_pkg::ST_VALID;
      return o;
   endfunction

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(99) < 28);
   endfunction

   // one transaction on req_, with a random gap ahead of it; valid stays
   // high on return so the next call can follow back to back
   task automatic send_counts(logic [15:0] fc, logic [15:0] ic);
      lsl_pkg::lsl_req_type r;
      r.full_count = fc;
      r.infrared_count = ic;
      if (idle_now()) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (idle_now());
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      lux_expected.push_back(lux_of(r));
      req_count++;
      @(negedge clock);
   endtask

   // registers only change with the pipeline drained
   task automatic write_csr(logic idx, logic [1:0] val);
      req_valid <= 1'b0;
      while (lux_expected.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == lsl_pkg::CSR_HIGH_GAIN) gain_hi = val[0];
      else int_sel = val;
   endtask

   task automatic set_mode(logic g, logic [1:0] s);
      write_csr(lsl_pkg::CSR_HIGH_GAIN, {1'b0, g});
      write_csr(lsl_pkg::CSR_INTEGRATION, s);
   endtask

   // receiver side stalls at random
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !idle_now();
   end

   // response checker
   always @(posedge clock) begin
      lsl_pkg::lsl_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (lux_expected.size() == 0) begin
            $error("unexpected response transaction");
            fail_count++;
         end else begin
            want = lux_expected.pop_front();
            if (rsp_payload.lux_value !== want.lux_value) begin
               $error("lux_value: expected %0h, got %0h", want.lux_value,
                      rsp_payload.lux_value);
               fail_count++;
            end
            if (rsp_payload.lux_status !== want.lux_status) begin
               $error("lux_status: expected %0d, got %0d", want.lux_status,
                      rsp_payload.lux_status);
               fail_count++;
            end
         end
      end
   end

   // extremes, every piece and every special case
   task automatic test_directed();
      send_counts(16'd0, 16'd0);          // zero full count
      send_counts(16'd0, 16'hFFFF);       // zero full checked before saturation
      send_counts(16'hFFFF, 16'd0);       // saturated full
      send_counts(16'd100, 16'hFFFF);     // saturated infrared
      send_counts(16'd100, 16'd131);      // ratio just above 1.30
      send_counts(16'd100, 16'd130);      // exactly 1.30
      send_counts(16'd100, 16'd80);       // piece edges
      send_counts(16'd100, 16'd81);
      send_counts(16'd100, 16'd61);
      send_counts(16'd100, 16'd62);
      send_counts(16'd100, 16'd50);
      send_counts(16'd100, 16'd51);
      send_counts(16'd1, 16'd0);
      send_counts(16'hFFFE, 16'd0);       // largest valid full count
      send_counts(16'hFFFE, 16'hFFFE);
      send_counts(16'hFFFE, 16'h7FFF);
      send_counts(16'd1, 16'd1);
      send_counts(16'h5555, 16'h2AAA);
      send_counts(16'hAAAA, 16'h5555);
   endtask

   task automatic test_all_modes();
      for (int g = 0; g < 2; g++)
         for (int s = 0; s < 4; s++) begin
            set_mode(g[0], s[1:0]);
            test_directed();
         end
   endtask

   // random pairs spread over all pieces
   task automatic test_random(int count);
      logic [15:0] fc, ic;
      for (int i = 0; i < count; i++) begin
         fc = $urandom_range(8) == 0 ? 16'($urandom_range(20)) : 16'($urandom);
         case ($urandom_range(5))
            0: ic = 16'($urandom);
            1: ic = 16'(($urandom_range(50) * fc) / 100);
            2: ic = 16'(($urandom_range(61, 50) * fc) / 100);
            3: ic = 16'(($urandom_range(80, 61) * fc) / 100);
            4: ic = 16'(($urandom_range(130, 80) * fc) / 100);
            default: ic = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(fc));
         endcase
         send_counts(fc, ic);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_index = lsl_pkg::CSR_HIGH_GAIN;
      csr_write_data = '0;
      gain_hi = 1'b0;
      int_sel = lsl_pkg::INT_402MS;
      fail_count = 0;
      rsp_count = 0;
      req_count = 0;
      no_idle = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();            // reset settings
      test_all_modes();
      for (int m = 0; m < 6; m++) begin
         set_mode(1'($urandom_range(1)), 2'($urandom_range(3)));
         no_idle = (m == 2);
         test_random(m == 2 ? 280 : 170);
      end
      req_valid <= 1'b0;
      no_idle = 1'b0;
      while (lux_expected.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      $display("Covered %0d request and %0d response transactions", req_count, rsp_count);
      $display("over both gains, all integration codes, every piece and status");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lsl_pkg.sv
hdl/lsl_ratio_cell.sv
hdl/lsl_lux_cell.sv
hdl/lsl_calc.sv
hdl/light_sensor_lux_calc.sv
test/tb.sv
